// File: hdl/frequency_table_histogram_core_macros.svh
// Assertion macros for the frequency table histogram core.
// Used by the top level only; depends on nothing else.
`ifndef FREQUENCY_TABLE_HISTOGRAM_CORE_MACROS_SVH
`define FREQUENCY_TABLE_HISTOGRAM_CORE_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define FTH_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
// Next-cycle implication outside reset.
`define FTH_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`endif

// File: hdl/fth_pkg.sv
// Package for the frequency table histogram core: types, constants, FSM states.
// No dependencies.
package fth_pkg;
	localparam int MAX_SAMPLES_DEF  = 1024;
	localparam int SAMPLE_WIDTH_DEF = 16;
	localparam int NC_LOW  = 7;
	localparam int NC_HIGH = 20;
	localparam int MAX_TABLE = NC_HIGH + 1;
	localparam int NC_W = 5;
	localparam int CFG_NUM_CLASSES = 0;

	typedef enum logic [2:0] {
		ST_LOAD, ST_DIV, ST_CLS_INIT, ST_SCAN, ST_DRAIN, ST_EMIT, ST_NEXT
	} fth_state_t;

	// Commands from controller to datapath.
	typedef struct packed {
		logic store;     // store the accepted sample
		logic div_start; // start the interval division
		logic cls_init;  // set class low to min, class index to zero
		logic scan_clr;  // clear count and address for a new class
		logic scan_step; // read next entry
		logic emit;      // load the output register
		logic cls_next;  // advance to next class
		logic set_clr;   // reset the set
	} fth_cmd_t;

	// Status from datapath to controller.
	typedef struct packed {
		logic div_done;
		logic scan_end;   // last address issued
		logic pipe_empty; // no reads in flight
		logic last_cls;   // current class is final
	} fth_sts_t;
endpackage

// File: hdl/fth_stream_if.sv
// Valid/ready stream interface with a generic payload.
// Depends on nothing.
interface fth_stream_if #(parameter int W = 8) (input logic clk);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: hdl/frequency_table_histogram_core.sv
// Top level of the frequency table histogram core: controller, datapath, APB register.
// Depends on fth_pkg, fth_stream_if, fth_ctrl, fth_datapath and the macros header.
//
//  channel | dir | payload
//  in_s    | in  | {last, sample}
//  out_s   | out | {last_class, overflow, class_width, data_max, data_min,
//          |     |  class_mark_x2, class_count, class_high, class_low}
//  apb     | in  | num_classes at address 0
//
// Samples load one per cycle while the core is in its load state. After the last
// sample the interval divider runs, then each class scans the store, plus
// the wait for the output register to be taken. Reset clears all control state;
// the store needs no clearing. A stalled output holds the scan.
`include "frequency_table_histogram_core_macros.svh"
module frequency_table_histogram_core import fth_pkg::*; #(
	parameter int MAX_SAMPLES  = MAX_SAMPLES_DEF,
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	fth_stream_if.sink  in_s,
	fth_stream_if.source out_s,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [0:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	fth_cmd_t cmd;
	fth_sts_t sts;
	logic [NC_W-1:0] nc_q;
	logic            ovalid_q;
	logic            take;

	// Configuration register.
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) nc_q <= NC_W'(NC_LOW);
		else if (psel && penable && pwrite && paddr == 1'(CFG_NUM_CLASSES))
			nc_q <= pwdata[NC_W-1:0];
	end
	assign prdata = (paddr == 1'(CFG_NUM_CLASSES)) ? {{(32-NC_W){1'b0}}, nc_q} : '0;

	// Output valid.
	assign take = out_s.valid && out_s.ready;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ovalid_q <= 1'b0;
		else if (cmd.emit) ovalid_q <= 1'b1;
		else if (take) ovalid_q <= 1'b0;
	end
	assign out_s.valid = ovalid_q;

	fth_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_s.valid),
		.in_last(in_s.data[SAMPLE_WIDTH]), .in_ready(in_s.ready),
		.out_busy(ovalid_q), .out_take(take), .sts(sts), .cmd(cmd)
	);

	fth_datapath #(.MAX_SAMPLES(MAX_SAMPLES), .SAMPLE_WIDTH(SAMPLE_WIDTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.in_sample(in_s.data[SAMPLE_WIDTH-1:0]), .num_classes(nc_q),
		.class_low(out_s.data[15:0]), .class_high(out_s.data[33:16]),
		.class_count(out_s.data[44:34]), .class_mark_x2(out_s.data[62:45]),
		.data_min(out_s.data[78:63]), .data_max(out_s.data[94:79]),
		.class_width(out_s.data[110:95]), .overflow(out_s.data[111]),
		.last_class(out_s.data[112])
	);

	`FTH_ASSERT_IMP(a_no_emit_over, cmd.emit, !ovalid_q || take)
	`FTH_ASSERT_NXT(a_emit_valid, cmd.emit, ovalid_q)
	`FTH_ASSERT_IMP(a_no_load_while_out, in_s.ready && in_s.valid, !cmd.emit)
endmodule

// File: hdl/fth_ctrl.sv
// Controller state machine for the histogram core.
// Depends on fth_pkg.
module fth_ctrl import fth_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     in_last,
	output logic     in_ready,
	input  logic     out_busy,
	input  logic     out_take,
	input  fth_sts_t sts,
	output fth_cmd_t cmd
);
	fth_state_t state_q, state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_LOAD;
		else state_q <= state_d;
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD: if (in_valid && in_last) state_d = ST_DIV;
			ST_DIV: if (sts.div_done) state_d = ST_CLS_INIT;
			ST_CLS_INIT: state_d = ST_SCAN;
			ST_SCAN: if (sts.scan_end) state_d = ST_DRAIN;
			ST_DRAIN: if (sts.pipe_empty) state_d = ST_EMIT;
			ST_EMIT: if (!out_busy || out_take) state_d = sts.last_cls ? ST_LOAD : ST_NEXT;
			ST_NEXT: state_d = ST_SCAN;
			default: state_d = ST_LOAD;
		endcase
	end

	// Outputs.
	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_LOAD: begin
				in_ready = 1'b1;
				cmd.store = in_valid;
				cmd.div_start = in_valid && in_last;
			end
			ST_CLS_INIT: begin
				cmd.cls_init = 1'b1;
				cmd.scan_clr = 1'b1;
			end
			ST_SCAN: cmd.scan_step = 1'b1;
			ST_EMIT: if (!out_busy || out_take) begin
				cmd.emit = 1'b1;
				cmd.set_clr = sts.last_cls;
			end
			ST_NEXT: begin
				cmd.cls_next = 1'b1;
				cmd.scan_clr = 1'b1;
			end
			default: ;
		endcase
	end
endmodule

// File: hdl/fth_div.sv
// Restoring divider for the class interval: ceil(range / nc), one bit a cycle.
// Depends on fth_pkg.
module fth_div import fth_pkg::*; #(
	parameter int DW = 17
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [NC_W-1:0] divisor,
	output logic          done,
	output logic [DW-1:0] quot
);
	localparam int CW = $clog2(DW + 1);
	logic [DW-1:0]   q_q;
	logic [NC_W:0]   r_q;
	logic [NC_W-1:0] d_q;
	logic [CW-1:0]   cnt_q;
	logic            busy_q;
	logic [NC_W+1:0] trial;

	assign trial = {r_q, q_q[DW-1]} - {2'b00, d_q};

	// Iterate one quotient bit each cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(DW);
		end else if (busy_q && cnt_q == '0) begin
			busy_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			r_q <= '0;
			d_q <= divisor;
		end else if (busy_q && cnt_q != '0) begin
			if (!trial[NC_W+1]) begin
				r_q <= trial[NC_W:0];
				q_q <= {q_q[DW-2:0], 1'b1};
			end else begin
				r_q <= {r_q[NC_W-1:0], q_q[DW-1]};
				q_q <= {q_q[DW-2:0], 1'b0};
			end
		end
	end

	assign done = busy_q && cnt_q == '0;
	assign quot = q_q;
endmodule

// File: hdl/fth_datapath.sv
// Datapath: sample store, min/max, interval divider, class scan and output register.
// Depends on fth_pkg and fth_div.
module fth_datapath import fth_pkg::*; #(
	parameter int MAX_SAMPLES  = MAX_SAMPLES_DEF,
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  fth_cmd_t                cmd,
	output fth_sts_t                sts,
	input  logic [SAMPLE_WIDTH-1:0] in_sample,
	input  logic [NC_W-1:0]         num_classes,
	output logic [15:0]             class_low,
	output logic [17:0]             class_high,
	output logic [10:0]             class_count,
	output logic [17:0]             class_mark_x2,
	output logic [15:0]             data_min,
	output logic [15:0]             data_max,
	output logic [15:0]             class_width,
	output logic                    overflow,
	output logic                    last_class
);
	localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
	localparam int CNTW = $clog2(MAX_SAMPLES + 1);
	localparam int SW = SAMPLE_WIDTH;
	localparam int EW = SW + 2;
	localparam int TW = $clog2(MAX_TABLE + 1);

	logic signed [SW-1:0] mem [MAX_SAMPLES];
	logic [CNTW-1:0]      count_q;
	logic signed [SW-1:0] min_q, max_q;
	logic                 drop_q;
	logic [CNTW-1:0]      raddr_q;
	logic                 rvalid_s1, rvalid_s2;
	logic signed [SW-1:0] rdata_s1;
	logic                 hit_s2;
	logic [CNTW-1:0]      ccnt_q;
	logic signed [EW-1:0] low_q, high_q;
	logic [TW-1:0]        idx_q;
	logic [SW:0]          intv_q;
	logic [NC_W-1:0]      nc;
	logic                 div_done;
	logic [SW:0]          quot;
	logic signed [SW-1:0] s;
	logic                 full;

	assign s = signed'(in_sample);
	assign full = count_q == CNTW'(MAX_SAMPLES);

	// Store accepted samples and track the range.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			min_q <= '0;
			max_q <= '0;
			drop_q <= 1'b0;
		end else if (cmd.set_clr) begin
			count_q <= '0;
			min_q <= '0;
			max_q <= '0;
			drop_q <= 1'b0;
		end else if (cmd.store) begin
			if (full) drop_q <= 1'b1;
			else begin
				count_q <= count_q + 1'b1;
				if (count_q == '0 || s < min_q) min_q <= s;
				if (count_q == '0 || s > max_q) max_q <= s;
			end
		end
	end

	// Sample memory, one write and one registered read port.
	always_ff @(posedge clk) begin
		if (cmd.store && !full) mem[count_q[AW-1:0]] <= s;
		rdata_s1 <= mem[raddr_q[AW-1:0]];
	end

	// Clamp the class number, then divide range + nc - 1 by nc.
	always_comb begin
		nc = num_classes;
		if (num_classes < NC_W'(NC_LOW)) nc = NC_W'(NC_LOW);
		else if (num_classes > NC_W'(NC_HIGH)) nc = NC_W'(NC_HIGH);
	end

	logic signed [SW:0] min_n, max_n;
	logic [SW:0]        dvd;
	always_comb begin
		// Divider starts while the final sample is stored; fold it in here.
		min_n = (SW+1)'(min_q);
		max_n = (SW+1)'(max_q);
		if (count_q == '0 || (!full && s < min_q)) min_n = (SW+1)'(s);
		if (count_q == '0 || (!full && s > max_q)) max_n = (SW+1)'(s);
		if (full) begin
			min_n = (SW+1)'(min_q);
			max_n = (SW+1)'(max_q);
		end
		dvd = (SW+1)'(max_n - min_n) + (SW+1)'(nc) - 1'b1;
	end

	fth_div #(.DW(SW + 1)) u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start), .dividend(dvd),
		.divisor(nc), .done(div_done), .quot(quot)
	);

	always_ff @(posedge clk) begin
		if (div_done) intv_q <= (quot == '0) ? (SW+1)'(1) : quot;
	end

	// Class bounds and index.
	always_ff @(posedge clk) begin
		if (cmd.cls_init) begin
			low_q  <= EW'(min_q);
			high_q <= EW'(min_q) + EW'(intv_q) - 1'b1;
			idx_q  <= '0;
		end else if (cmd.cls_next) begin
			low_q  <= low_q + EW'(intv_q);
			high_q <= high_q + EW'(intv_q);
			idx_q  <= idx_q + 1'b1;
		end
	end

	// Scan pipeline: address, read, compare, count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raddr_q <= '0;
			rvalid_s1 <= 1'b0;
			rvalid_s2 <= 1'b0;
		end else begin
			rvalid_s1 <= cmd.scan_step && raddr_q < count_q;
			rvalid_s2 <= rvalid_s1;
			if (cmd.scan_clr) raddr_q <= '0;
			else if (cmd.scan_step) raddr_q <= raddr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		hit_s2 <= EW'(rdata_s1) >= low_q && EW'(rdata_s1) <= high_q;
		if (cmd.scan_clr) ccnt_q <= '0;
		else if (rvalid_s2 && hit_s2) ccnt_q <= ccnt_q + 1'b1;
	end

	assign sts.div_done   = div_done;
	assign sts.scan_end   = cmd.scan_step && (raddr_q + 1'b1 >= count_q);
	assign sts.pipe_empty = !rvalid_s1 && !rvalid_s2;
	assign sts.last_cls   = (low_q + signed'(EW'(intv_q)) > EW'(max_q)) ||
		(idx_q == TW'(MAX_TABLE - 1));

	// Output register.
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			class_low     <= 16'(low_q);
			class_high    <= 18'(high_q);
			class_count   <= 11'(ccnt_q);
			class_mark_x2 <= 18'(low_q + high_q);
			data_min      <= 16'(min_q);
			data_max      <= 16'(max_q);
			class_width   <= 16'(intv_q);
			overflow      <= drop_q;
			last_class    <= sts.last_cls;
		end
	end
endmodule

// File: test/frequency_table_histogram_core_tb.sv
// Testbench for the frequency table histogram core: streams sample sets, predicts every class beat.
// Depends on fth_pkg, fth_stream_if and frequency_table_histogram_core.
`timescale 1ns / 100ps
module frequency_table_histogram_core_tb import fth_pkg::*;;

	typedef struct packed {
		logic        last_class;
		logic        overflow;
		logic [15:0] class_width;
		logic [15:0] data_max;
		logic [15:0] data_min;
		logic [17:0] class_mark_x2;
		logic [10:0] class_count;
		logic [17:0] class_high;
		logic [15:0] class_low;
	} class_beat_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [0:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	fth_stream_if #(.W(17))  in_if (clk);
	fth_stream_if #(.W(113)) out_if (clk);

	frequency_table_histogram_core i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_s    (in_if),
		.out_s   (out_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Predictor state, mirroring the block's set and register.
	int          set_samples[$];
	int          set_min;
	int          set_max;
	bit          set_dropped;
	logic [4:0]  classes_reg;
	class_beat_t class_table_q[$];

	int mismatches;
	int sent_items;
	bit no_idle;
	int hold_len;

	// Clock.
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Work out the class table of the closing set and queue its beats.
	function automatic void predict_table();
		int nc;
		int interval;
		int lo;
		int hi;
		int cnt;
		int n;
		class_beat_t b;
		nc = classes_reg;
		if (nc < NC_LOW) nc = NC_LOW;
		if (nc > NC_HIGH) nc = NC_HIGH;
		interval = (set_max - set_min + nc - 1) / nc;
		if (interval < 1) interval = 1;
		lo = set_min;
		n = 0;
		while (lo <= set_max && n < MAX_TABLE) begin
			hi = lo + interval - 1;
			cnt = 0;
			foreach (set_samples[i])
				if (set_samples[i] >= lo && set_samples[i] <= hi) cnt++;
			b.class_low     = lo[15:0];
			b.class_high    = hi[17:0];
			b.class_count   = cnt[10:0];
			b.class_mark_x2 = 18'(lo + hi);
			b.data_min      = set_min[15:0];
			b.data_max      = set_max[15:0];
			b.class_width   = interval[15:0];
			b.overflow      = set_dropped;
			b.last_class    = (lo + interval > set_max) || (n + 1 >= MAX_TABLE);
			class_table_q.push_back(b);
			n++;
			lo += interval;
		end
		set_samples.delete();
		set_min = 0;
		set_max = 0;
		set_dropped = 1'b0;
	endfunction

	// Fold one accepted sample into the predicted set.
	function automatic void absorb_sample(logic signed [15:0] s, logic lst);
		int v;
		v = s;
		if (set_samples.size() < MAX_SAMPLES_DEF) begin
			if (set_samples.size() == 0) begin
				set_min = v;
				set_max = v;
			end else begin
				if (v < set_min) set_min = v;
				if (v > set_max) set_max = v;
			end
			set_samples.push_back(v);
		end else begin
			set_dropped = 1'b1;
		end
		if (lst) predict_table();
	endfunction

	// Send one sample beat, after a random gap unless idling is off.
	task automatic send_sample(logic signed [15:0] s, logic lst);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			in_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_if.valid <= 1'b1;
		in_if.data  <= {lst, s};
		do @(posedge clk); while (!in_if.ready);
		absorb_sample(s, lst);
		sent_items++;
	endtask

	// Wait until the table is drained and the block has settled.
	task automatic wait_drained();
		in_if.valid <= 1'b0;
		wait (class_table_q.size() == 0);
		repeat (40) @(posedge clk);
	endtask

	// Register write followed by a read back of the same register.
	task automatic write_classes(logic [4:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= 1'(CFG_NUM_CLASSES);
		pwdata  <= {27'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		classes_reg = value;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[4:0] !== value) begin
			if (mismatches < 10)
				$display("register read: expected %0d actual %0d", value, prdata[4:0]);
			mismatches++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Send a set of random samples, spread chosen per set.
	task automatic send_random_set(int len);
		int kind;
		int base;
		logic signed [15:0] s;
		kind = $urandom_range(0, 3);
		base = $urandom_range(0, 65535) - 32768;
		for (int i = 0; i < len; i++) begin
			case (kind)
				0: s = 16'($urandom);
				1: s = 16'(base + $urandom_range(0, 40));
				2: s = 16'(base);
				default: s = 16'($urandom_range(0, 300) - 150);
			endcase
			send_sample(s, i == len - 1);
		end
	endtask

	// Extremes of the sample field and a one-sample set.
	task automatic test_extremes();
		send_sample(16'sh8000, 1'b0);
		send_sample(16'sh7fff, 1'b1);
		send_sample(16'sh7fff, 1'b1);
		send_sample(16'sh8000, 1'b1);
		send_sample(-16'sd3, 1'b0);
		send_sample(16'sd0, 1'b0);
		send_sample(16'sd17, 1'b1);
		wait_drained();
	endtask

	// Every sample equal gives one class of width one.
	task automatic test_all_equal();
		repeat (4) send_sample(16'sd5, 1'b0);
		send_sample(16'sd5, 1'b1);
		wait_drained();
	endtask

	// Class counts below and above the legal range are clamped.
	task automatic test_class_clamp();
		logic [4:0] vals[4] = '{5'd0, 5'd31, 5'd20, 5'd7};
		foreach (vals[k]) begin
			write_classes(vals[k]);
			send_sample(16'sh8000, 1'b0);
			send_sample(16'sd100, 1'b0);
			send_sample(16'sh7fff, 1'b1);
			wait_drained();
		end
	endtask

	// A full store drops further samples and flags the set.
	task automatic test_store_full();
		no_idle = 1'b1;
		for (int i = 0; i < MAX_SAMPLES_DEF + 6; i++)
			send_sample(16'($urandom_range(0, 2000) - 1000),
				i == MAX_SAMPLES_DEF + 5);
		no_idle = 1'b0;
		wait_drained();
	endtask

	// The receiver holds off while the sender keeps offering sets.
	task automatic test_output_hold();
		hold_len = 400;
		repeat (6) send_random_set(8);
		wait_drained();
	endtask

	// Random sets, the class count changed now and then between them.
	task automatic test_random_sets();
		int start;
		start = sent_items;
		while (sent_items - start < 370) begin
			no_idle = ($urandom_range(0, 5) == 0);
			send_random_set($urandom_range(0, 9) == 0 ? $urandom_range(40, 80)
				: $urandom_range(1, 20));
			if ($urandom_range(0, 4) == 0) begin
				wait_drained();
				write_classes(5'($urandom));
			end else if ($urandom_range(0, 9) == 0) begin
				wait_drained();
			end
		end
		no_idle = 1'b0;
		wait_drained();
	endtask

	// Receiver: random gaps, with an occasional long hold.
	initial begin
		int gap;
		out_if.ready = 1'b0;
		forever begin
			gap = no_idle ? 0 : $urandom_range(0, 8);
			if (hold_len > 0) begin
				gap = hold_len;
				hold_len = 0;
			end
			if (gap > 0) begin
				out_if.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_if.ready <= 1'b1;
			do @(posedge clk); while (!out_if.valid);
		end
	end

	// Compare each class beat with the oldest predicted one.
	always @(posedge clk) begin
		class_beat_t got;
		class_beat_t want;
		if (arst_n && out_if.valid && out_if.ready) begin
			got = out_if.data;
			if (class_table_q.size() == 0) begin
				if (mismatches < 10) $display("unexpected class beat: actual %p", got);
				mismatches++;
			end else begin
				want = class_table_q.pop_front();
				if (got !== want) begin
					if (mismatches < 10)
						$display("class beat mismatch: expected %p actual %p", want, got);
					mismatches++;
				end
			end
		end
	end

	// Run limit.
	initial begin
		#20ms;
		$display("== FAIL ==");
		$finish;
	end

	// Test sequence.
	initial begin
		arst_n      = 1'b0;
		in_if.valid = 1'b0;
		in_if.data  = '0;
		psel        = 1'b0;
		penable     = 1'b0;
		pwrite      = 1'b0;
		paddr       = '0;
		pwdata      = '0;
		mismatches  = 0;
		sent_items  = 0;
		no_idle     = 1'b0;
		hold_len    = 0;
		classes_reg = 5'd7;
		set_min     = 0;
		set_max     = 0;
		set_dropped = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_extremes();
		test_all_equal();
		test_class_clamp();
		test_store_full();
		test_output_hold();
		test_random_sets();

		if (mismatches == 0 && class_table_q.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end
endmodule

// File: files.f
+incdir+hdl
hdl/fth_pkg.sv
hdl/fth_stream_if.sv
hdl/fth_ctrl.sv
hdl/fth_div.sv
hdl/fth_datapath.sv
hdl/frequency_table_histogram_core.sv
test/frequency_table_histogram_core_tb.sv
